@@ hw/rtl/sexpr_pkg.sv @@
// Shared types, character codes and helper functions for the S-expression tokenizer.
package sexpr_pkg;

    localparam int FIELD_W     = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CHAR_DASH       = 8'h2D;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CHAR_CR         = 8'h0D;
    localparam logic [7:0] CHAR_LF         = 8'h0A;
    localparam logic [7:0] CHAR_LPAREN     = 8'h28;
    localparam logic [7:0] CHAR_RPAREN     = 8'h29;
    localparam logic [7:0] CHAR_QUOTE      = 8'h27;
    localparam logic [7:0] CHAR_DQUOTE     = 8'h22;
    localparam logic [7:0] CHAR_SPACE      = 8'h20;
    localparam logic [7:0] CHAR_TAB        = 8'h09;

    typedef enum logic [2:0] {
        KIND_LPAREN = 3'd0,
        KIND_RPAREN = 3'd1,
        KIND_QUOTE  = 3'd2,
        KIND_SYMBOL = 3'd3,
        KIND_STRING = 3'd4,
        KIND_ERROR  = 3'd5,
        KIND_EOT    = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE              = 3'd0,
        ERR_UNKNOWN_CHAR      = 3'd1,
        ERR_UNCLOSED_STRING   = 3'd2,
        ERR_NEWLINE_IN_STRING = 3'd3,
        ERR_BAD_SYMBOL_CHAR   = 3'd4
    } err_t;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_SYMBOL = 2'd1,
        MODE_STRING = 2'd2,
        MODE_HALT   = 2'd3
    } mode_t;

    typedef struct packed {
        kind_t                kind;
        err_t                 err;
        logic [FIELD_W-1:0]   line;
        logic [FIELD_W-1:0]   column;
        logic [FIELD_W-1:0]   offset;
        logic [FIELD_W-1:0]   length;
    } token_t;

    // One record holds every token that a single item produces.
    typedef struct packed {
        logic   two;
        token_t first;
        token_t second;
    } record_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

endpackage

@@ hw/rtl/sexpr_queue.sv @@
// Small record queue that decouples the lexer front end from the output stage.
module sexpr_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sexpr_pkg::record_t  push_data,
    output logic                full,
    input  logic                pop,
    output sexpr_pkg::record_t  pop_data,
    output logic                empty
);

    localparam int DEPTH = sexpr_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sexpr_pkg::record_t store_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hw/rtl/sexpr_front.sv @@
// Lexer front end: tracks mode and position and turns each item into a token record.
module sexpr_front
#(
    parameter int POSITION_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          character,
    input  logic                start_of_text,
    input  logic                end_of_text,
    output logic                push,
    output sexpr_pkg::record_t  rec
);

    localparam int P  = POSITION_BITS;
    localparam int FW = sexpr_pkg::FIELD_W;
    localparam logic [P-1:0] POS_ONE = P'(1);

    sexpr_pkg::mode_t mode_reg, mode_next, mode_e;
    logic [P-1:0] off_reg, off_next, off_e;
    logic [P-1:0] line_reg, line_next, line_e;
    logic [P-1:0] col_reg, col_next, col_e;
    logic [P-1:0] toff_reg, toff_next, toff_e;
    logic [P-1:0] tline_reg, tline_next, tline_e;
    logic [P-1:0] tcol_reg, tcol_next, tcol_e;

    logic               has_first;
    logic               do_idle;
    logic               sym_end;
    logic               idle_emit;
    sexpr_pkg::token_t  idle_tok;

    function automatic logic [P-1:0] sat_inc(input logic [P-1:0] v);
        return (&v) ? v : v + POS_ONE;
    endfunction

    function automatic sexpr_pkg::token_t make_tok(
        input sexpr_pkg::kind_t k,
        input sexpr_pkg::err_t  e,
        input logic [P-1:0]     ln,
        input logic [P-1:0]     cl,
        input logic [P-1:0]     of,
        input logic [P-1:0]     len
    );
        sexpr_pkg::token_t t;
        t.kind   = k;
        t.err    = e;
        t.line   = FW'(ln);
        t.column = FW'(cl);
        t.offset = FW'(of);
        t.length = FW'(len);
        return t;
    endfunction

    always_comb
    begin
        mode_e  = start_of_text ? sexpr_pkg::MODE_IDLE : mode_reg;
        off_e   = start_of_text ? '0 : off_reg;
        line_e  = start_of_text ? POS_ONE : line_reg;
        col_e   = start_of_text ? POS_ONE : col_reg;
        toff_e  = start_of_text ? '0 : toff_reg;
        tline_e = start_of_text ? POS_ONE : tline_reg;
        tcol_e  = start_of_text ? POS_ONE : tcol_reg;

        mode_next  = mode_e;
        off_next   = off_e;
        line_next  = line_e;
        col_next   = col_e;
        toff_next  = toff_e;
        tline_next = tline_e;
        tcol_next  = tcol_e;

        rec       = '0;
        has_first = 1'b0;
        do_idle   = 1'b0;
        sym_end   = 1'b0;
        idle_emit = 1'b0;
        idle_tok  = '0;

        priority if (mode_e == sexpr_pkg::MODE_HALT)
        begin
            has_first = 1'b0;
        end
        else if (end_of_text)
        begin
            has_first = 1'b1;
            unique case (mode_e)
                sexpr_pkg::MODE_STRING:
                begin
                    rec.first = make_tok(sexpr_pkg::KIND_ERROR,
                        sexpr_pkg::ERR_UNCLOSED_STRING, tline_e, tcol_e, toff_e,
                        off_e - toff_e);
                    mode_next = sexpr_pkg::MODE_HALT;
                end
                sexpr_pkg::MODE_SYMBOL:
                begin
                    rec.first = make_tok(sexpr_pkg::KIND_SYMBOL, sexpr_pkg::ERR_NONE,
                        tline_e, tcol_e, toff_e, off_e - toff_e);
                    rec.second = make_tok(sexpr_pkg::KIND_EOT, sexpr_pkg::ERR_NONE,
                        line_e, col_e, off_e, '0);
                    rec.two   = 1'b1;
                    mode_next = sexpr_pkg::MODE_IDLE;
                end
                default:
                begin
                    rec.first = make_tok(sexpr_pkg::KIND_EOT, sexpr_pkg::ERR_NONE,
                        line_e, col_e, off_e, '0);
                end
            endcase
        end
        else
        begin
            unique case (mode_e)
                sexpr_pkg::MODE_SYMBOL:
                begin
                    priority if (sexpr_pkg::is_alpha(character)
                        || (character == sexpr_pkg::CHAR_DASH)
                        || (character == sexpr_pkg::CHAR_UNDERSCORE))
                    begin
                        off_next = sat_inc(off_e);
                        col_next = sat_inc(col_e);
                    end
                    else if (sexpr_pkg::is_space(character)
                        || (character == sexpr_pkg::CHAR_RPAREN))
                    begin
                        rec.first = make_tok(sexpr_pkg::KIND_SYMBOL,
                            sexpr_pkg::ERR_NONE, tline_e, tcol_e, toff_e,
                            off_e - toff_e);
                        has_first = 1'b1;
                        mode_next = sexpr_pkg::MODE_IDLE;
                        do_idle   = 1'b1;
                        sym_end   = 1'b1;
                    end
                    else
                    begin
                        rec.first = make_tok(sexpr_pkg::KIND_ERROR,
                            sexpr_pkg::ERR_BAD_SYMBOL_CHAR, tline_e, tcol_e, toff_e,
                            sat_inc(off_e - toff_e));
                        has_first = 1'b1;
                        mode_next = sexpr_pkg::MODE_HALT;
                    end
                end
                sexpr_pkg::MODE_STRING:
                begin
                    if (character == sexpr_pkg::CHAR_LF)
                    begin
                        rec.first = make_tok(sexpr_pkg::KIND_ERROR,
                            sexpr_pkg::ERR_NEWLINE_IN_STRING, tline_e, tcol_e, toff_e,
                            sat_inc(off_e - toff_e));
                        has_first = 1'b1;
                        mode_next = sexpr_pkg::MODE_HALT;
                    end
                    else
                    begin
                        off_next = sat_inc(off_e);
                        col_next = sat_inc(col_e);
                        if ((character == sexpr_pkg::CHAR_DQUOTE)
                            || (character == sexpr_pkg::CHAR_QUOTE))
                        begin
                            rec.first = make_tok(sexpr_pkg::KIND_STRING,
                                sexpr_pkg::ERR_NONE, tline_e, tcol_e, toff_e,
                                sat_inc(off_e) - toff_e);
                            has_first = 1'b1;
                            mode_next = sexpr_pkg::MODE_IDLE;
                        end
                    end
                end
                default:
                begin
                    do_idle = 1'b1;
                end
            endcase
        end

        // A character that ends a symbol is then handled as it would be between tokens.
        if (do_idle)
        begin
            priority if (character == sexpr_pkg::CHAR_CR)
            begin
                off_next = sat_inc(off_e);
            end
            else if (character == sexpr_pkg::CHAR_LF)
            begin
                off_next  = sat_inc(off_e);
                line_next = sat_inc(line_e);
                col_next  = POS_ONE;
            end
            else if (sexpr_pkg::is_space(character))
            begin
                off_next = sat_inc(off_e);
                col_next = sat_inc(col_e);
            end
            else if ((character == sexpr_pkg::CHAR_LPAREN)
                || (character == sexpr_pkg::CHAR_RPAREN)
                || (character == sexpr_pkg::CHAR_QUOTE))
            begin
                idle_emit = 1'b1;
                idle_tok  = make_tok(
                    (character == sexpr_pkg::CHAR_LPAREN) ? sexpr_pkg::KIND_LPAREN :
                    (character == sexpr_pkg::CHAR_RPAREN) ? sexpr_pkg::KIND_RPAREN :
                                                            sexpr_pkg::KIND_QUOTE,
                    sexpr_pkg::ERR_NONE, line_e, col_e, off_e, POS_ONE);
                off_next = sat_inc(off_e);
                col_next = sat_inc(col_e);
            end
            else if (sexpr_pkg::is_alpha(character)
                || (character == sexpr_pkg::CHAR_DQUOTE))
            begin
                toff_next  = off_e;
                tline_next = line_e;
                tcol_next  = col_e;
                off_next   = sat_inc(off_e);
                col_next   = sat_inc(col_e);
                mode_next  = sexpr_pkg::is_alpha(character) ? sexpr_pkg::MODE_SYMBOL
                                                            : sexpr_pkg::MODE_STRING;
            end
            else
            begin
                toff_next  = off_e;
                tline_next = line_e;
                tcol_next  = col_e;
                idle_emit  = 1'b1;
                idle_tok   = make_tok(sexpr_pkg::KIND_ERROR, sexpr_pkg::ERR_UNKNOWN_CHAR,
                    line_e, col_e, off_e, POS_ONE);
                mode_next  = sexpr_pkg::MODE_HALT;
            end

            if (idle_emit)
            begin
                if (sym_end)
                begin
                    rec.second = idle_tok;
                    rec.two    = 1'b1;
                end
                else
                begin
                    rec.first = idle_tok;
                    has_first = 1'b1;
                end
            end
        end

        push = accept && has_first;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= sexpr_pkg::MODE_IDLE;
            off_reg   <= '0;
            line_reg  <= POS_ONE;
            col_reg   <= POS_ONE;
            toff_reg  <= '0;
            tline_reg <= POS_ONE;
            tcol_reg  <= POS_ONE;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            off_reg   <= off_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            toff_reg  <= toff_next;
            tline_reg <= tline_next;
            tcol_reg  <= tcol_next;
        end
    end

endmodule

@@ hw/rtl/sexpr_back.sv @@
// Output stage: takes queued records and hands out one token per cycle unless stalled.
module sexpr_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  sexpr_pkg::record_t  rec,
    input  logic                empty,
    output logic                pop,
    output logic                token_valid,
    input  logic                token_stall,
    output logic [2:0]          token_kind,
    output logic [2:0]          error_kind,
    output logic [15:0]         start_line,
    output logic [15:0]         start_column,
    output logic [15:0]         start_offset,
    output logic [15:0]         token_length,
    output logic                last
);

    sexpr_pkg::record_t cur_reg, cur_next;
    logic               valid_reg, valid_next;
    logic               sel_reg, sel_next;
    logic               take;
    logic               to_second;
    logic               need_load;
    sexpr_pkg::token_t  tok;

    always_comb
    begin
        take       = valid_reg && !token_stall;
        to_second  = take && !sel_reg && cur_reg.two;
        need_load  = !valid_reg || (take && !to_second);
        pop        = need_load && !empty;
        cur_next   = cur_reg;
        valid_next = valid_reg;
        sel_next   = sel_reg;
        if (to_second)
        begin
            sel_next = 1'b1;
        end
        else if (need_load)
        begin
            valid_next = !empty;
            sel_next   = 1'b0;
            if (!empty)
            begin
                cur_next = rec;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            sel_reg   <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    assign tok          = sel_reg ? cur_reg.second : cur_reg.first;
    assign token_valid  = valid_reg;
    assign token_kind   = tok.kind;
    assign error_kind   = tok.err;
    assign start_line   = tok.line;
    assign start_column = tok.column;
    assign start_offset = tok.offset;
    assign token_length = tok.length;
    assign last         = sel_reg || !cur_reg.two;

endmodule

@@ hw/rtl/sexpr_tokenizer_unit.sv @@
// Top level of the S-expression tokenizer: lexer front end, record queue and output stage.
//
// The block accepts one character item per clock cycle. Each item is classified and
// its tokens are built in the same cycle it is accepted, then placed as one record in
// a two-entry queue; the output stage delivers one token per cycle from that queue,
// so an item that yields two tokens (a symbol closed by a right parenthesis or by end
// of text) hands them out in turn. The first token of an item is written into the
// queue and then registered in the output stage before it appears. Character input
// stalls only while the queue is full, which happens only when the output side stalls
// or drains two-token items. Positions are tracked with POSITION_BITS-bit saturating
// counters and reported in 16-bit fields.
module sexpr_tokenizer_unit
#(
    parameter int POSITION_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    output logic        char_stall,
    input  logic [7:0]  character,
    input  logic        start_of_text,
    input  logic        end_of_text,
    output logic        token_valid,
    input  logic        token_stall,
    output logic [2:0]  token_kind,
    output logic [2:0]  error_kind,
    output logic [15:0] start_line,
    output logic [15:0] start_column,
    output logic [15:0] start_offset,
    output logic [15:0] token_length,
    output logic        last
);

    logic               accept;
    logic               push;
    logic               pop;
    logic               full;
    logic               empty;
    sexpr_pkg::record_t push_rec;
    sexpr_pkg::record_t pop_rec;

    assign char_stall = full;
    assign accept     = char_valid && !full;

    sexpr_front #(
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .character     (character),
        .start_of_text (start_of_text),
        .end_of_text   (end_of_text),
        .push          (push),
        .rec           (push_rec)
    );

    sexpr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_rec),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_rec),
        .empty     (empty)
    );

    sexpr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .rec          (pop_rec),
        .empty        (empty),
        .pop          (pop),
        .token_valid  (token_valid),
        .token_stall  (token_stall),
        .token_kind   (token_kind),
        .error_kind   (error_kind),
        .start_line   (start_line),
        .start_column (start_column),
        .start_offset (start_offset),
        .token_length (token_length),
        .last         (last)
    );

endmodule

@@ hw/rtl/sexpr_checker.sv @@
// Port-level assertions for the S-expression tokenizer and their bind to the top level.
module sexpr_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        token_valid,
    input logic        token_stall,
    input logic [2:0]  token_kind,
    input logic [2:0]  error_kind,
    input logic [15:0] start_line,
    input logic [15:0] start_column,
    input logic [15:0] start_offset,
    input logic [15:0] token_length,
    input logic        last
);

    a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_stall |=> token_valid)
        else $error("Output item withdrawn while stalled.");

    a_out_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_stall |=> $stable(token_kind) && $stable(token_length)
            && $stable(start_offset) && $stable(last))
        else $error("Output payload changed while stalled.");

    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && (token_kind == sexpr_pkg::KIND_ERROR)
            |-> last && (error_kind != sexpr_pkg::ERR_NONE))
        else $error("Error token is not the final token of its item or has no kind.");

    a_eot_form: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && (token_kind == sexpr_pkg::KIND_EOT)
            |-> last && (token_length == '0) && (error_kind == sexpr_pkg::ERR_NONE))
        else $error("End-of-text token is malformed.");

    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid |-> (start_line != '0) && (start_column != '0))
        else $error("Token reports line or column zero.");

endmodule

bind sexpr_tokenizer_unit sexpr_checker u_checker (.*);

@@ tb/testbench.sv @@
// Testbench for the S-expression tokenizer: random and directed texts checked against a predictor.
`timescale 1ns / 1ps

module testbench;

    localparam int ITEM_GOAL   = 1900;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct packed {
        sexpr_pkg::token_t tok;
        logic              last;
    } expected_token_t;

    class token_scoreboard;
        sexpr_pkg::mode_t  mode;
        logic [15:0]       offset;
        logic [15:0]       line;
        logic [15:0]       column;
        logic [15:0]       mark_offset;
        logic [15:0]       mark_line;
        logic [15:0]       mark_column;
        expected_token_t   pending_q[$];
        int                errors;

        function new();
            restart();
            errors = 0;
        endfunction

        function void restart();
            mode        = sexpr_pkg::MODE_IDLE;
            offset      = 16'd0;
            line        = 16'd1;
            column      = 16'd1;
            mark_offset = 16'd0;
            mark_line   = 16'd1;
            mark_column = 16'd1;
        endfunction

        function logic [15:0] bump(logic [15:0] v);
            return (v == 16'hFFFF) ? v : v + 16'd1;
        endfunction

        function bit is_letter(logic [7:0] c);
            logic [7:0] lower;
            lower = c | 8'h20;
            return (lower >= "a") && (lower <= "z");
        endfunction

        function bit is_blank(logic [7:0] c);
            return (c == sexpr_pkg::CHAR_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
        endfunction

        function void push_token(sexpr_pkg::kind_t kind, sexpr_pkg::err_t err,
                                 logic [15:0] ln, logic [15:0] col,
                                 logic [15:0] off, logic [15:0] len);
            expected_token_t t;
            t.tok.kind   = kind;
            t.tok.err    = err;
            t.tok.line   = ln;
            t.tok.column = col;
            t.tok.offset = off;
            t.tok.length = len;
            t.last       = 1'b0;
            pending_q.push_back(t);
        endfunction

        function void step_column();
            offset = bump(offset);
            column = bump(column);
        endfunction

        function void mark();
            mark_offset = offset;
            mark_line   = line;
            mark_column = column;
        endfunction

        function void close_symbol();
            push_token(sexpr_pkg::KIND_SYMBOL, sexpr_pkg::ERR_NONE, mark_line, mark_column,
                       mark_offset, offset - mark_offset);
            mode = sexpr_pkg::MODE_IDLE;
        endfunction

        function void raise_error(sexpr_pkg::err_t err, bit with_char);
            logic [15:0] len;
            len = offset - mark_offset;
            if (with_char)
                len = bump(len);
            push_token(sexpr_pkg::KIND_ERROR, err, mark_line, mark_column, mark_offset, len);
            mode = sexpr_pkg::MODE_HALT;
        endfunction

        function void idle_char(logic [7:0] c);
            if (c == sexpr_pkg::CHAR_CR)
                offset = bump(offset);
            else if (c == sexpr_pkg::CHAR_LF)
            begin
                offset = bump(offset);
                line   = bump(line);
                column = 16'd1;
            end
            else if (is_blank(c))
                step_column();
            else if (c == sexpr_pkg::CHAR_LPAREN || c == sexpr_pkg::CHAR_RPAREN
                || c == sexpr_pkg::CHAR_QUOTE)
            begin
                push_token((c == sexpr_pkg::CHAR_LPAREN) ? sexpr_pkg::KIND_LPAREN :
                           (c == sexpr_pkg::CHAR_RPAREN) ? sexpr_pkg::KIND_RPAREN :
                                                           sexpr_pkg::KIND_QUOTE,
                           sexpr_pkg::ERR_NONE, line, column, offset, 16'd1);
                step_column();
            end
            else if (is_letter(c))
            begin
                mark();
                step_column();
                mode = sexpr_pkg::MODE_SYMBOL;
            end
            else if (c == sexpr_pkg::CHAR_DQUOTE)
            begin
                mark();
                step_column();
                mode = sexpr_pkg::MODE_STRING;
            end
            else
            begin
                mark();
                raise_error(sexpr_pkg::ERR_UNKNOWN_CHAR, 1'b1);
            end
        endfunction

        // Returns 0 when the item is ignored because lexing has stopped on an error.
        function bit note_item(logic [7:0] c, logic sot, logic eot);
            int before_n;
            before_n = pending_q.size();
            if (sot)
                restart();
            if (mode == sexpr_pkg::MODE_HALT)
                return 1'b0;
            if (eot)
            begin
                if (mode == sexpr_pkg::MODE_STRING)
                    raise_error(sexpr_pkg::ERR_UNCLOSED_STRING, 1'b0);
                else
                begin
                    if (mode == sexpr_pkg::MODE_SYMBOL)
                        close_symbol();
                    push_token(sexpr_pkg::KIND_EOT, sexpr_pkg::ERR_NONE, line, column, offset,
                               16'd0);
                end
            end
            else if (mode == sexpr_pkg::MODE_SYMBOL)
            begin
                if (is_letter(c) || c == sexpr_pkg::CHAR_DASH
                    || c == sexpr_pkg::CHAR_UNDERSCORE)
                    step_column();
                else if (is_blank(c) || c == sexpr_pkg::CHAR_RPAREN)
                begin
                    close_symbol();
                    idle_char(c);
                end
                else
                    raise_error(sexpr_pkg::ERR_BAD_SYMBOL_CHAR, 1'b1);
            end
            else if (mode == sexpr_pkg::MODE_STRING)
            begin
                if (c == sexpr_pkg::CHAR_LF)
                    raise_error(sexpr_pkg::ERR_NEWLINE_IN_STRING, 1'b1);
                else
                begin
                    step_column();
                    if (c == sexpr_pkg::CHAR_DQUOTE || c == sexpr_pkg::CHAR_QUOTE)
                    begin
                        push_token(sexpr_pkg::KIND_STRING, sexpr_pkg::ERR_NONE, mark_line,
                                   mark_column, mark_offset, offset - mark_offset);
                        mode = sexpr_pkg::MODE_IDLE;
                    end
                end
            end
            else
                idle_char(c);
            if (pending_q.size() > before_n)
                pending_q[pending_q.size() - 1].last = 1'b1;
            return 1'b1;
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got)
            begin
                errors++;
                $error("%s: expected %0d, actual %0d", name, want, got);
            end
        endfunction

        function void check_token(sexpr_pkg::token_t got, logic got_last);
            expected_token_t want;
            if (pending_q.size() == 0)
            begin
                errors++;
                $error("token_kind: expected none, actual %0d", got.kind);
                return;
            end
            want = pending_q.pop_front();
            compare_field("token_kind", want.tok.kind, got.kind);
            compare_field("error_kind", want.tok.err, got.err);
            compare_field("start_line", want.tok.line, got.line);
            compare_field("start_column", want.tok.column, got.column);
            compare_field("start_offset", want.tok.offset, got.offset);
            compare_field("token_length", want.tok.length, got.length);
            compare_field("last", want.last, got_last);
        endfunction
    endclass

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        char_valid    = 1'b0;
    logic        char_stall;
    logic [7:0]  character     = 8'h00;
    logic        start_of_text = 1'b0;
    logic        end_of_text   = 1'b0;
    logic        token_valid;
    logic        token_stall   = 1'b0;
    logic [2:0]  token_kind;
    logic [2:0]  error_kind;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [15:0] start_offset;
    logic [15:0] token_length;
    logic        last;

    token_scoreboard sb = new();
    bit  idling     = 1'b1;
    bit  fresh_text = 1'b0;
    bit  garble     = 1'b0;
    int  handled    = 0;
    int  cycles     = 0;

    sexpr_tokenizer_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .char_valid    (char_valid),
        .char_stall    (char_stall),
        .character     (character),
        .start_of_text (start_of_text),
        .end_of_text   (end_of_text),
        .token_valid   (token_valid),
        .token_stall   (token_stall),
        .token_kind    (token_kind),
        .error_kind    (error_kind),
        .start_line    (start_line),
        .start_column  (start_column),
        .start_offset  (start_offset),
        .token_length  (token_length),
        .last          (last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge clk)
    begin : token_monitor
        sexpr_pkg::token_t got;
        if (rst_n && token_valid && !token_stall)
        begin
            got.kind   = sexpr_pkg::kind_t'(token_kind);
            got.err    = sexpr_pkg::err_t'(error_kind);
            got.line   = start_line;
            got.column = start_column;
            got.offset = start_offset;
            got.length = token_length;
            sb.check_token(got, last);
        end
    end

    always
    begin : token_backpressure
        @(posedge clk);
        if (idling && $urandom_range(0, 4) == 0)
        begin
            token_stall <= 1'b1;
            repeat ($urandom_range(1, 7)) @(posedge clk);
            token_stall <= 1'b0;
        end
    end

    task automatic push_char(logic [7:0] c, logic sot, logic eot);
        if (idling && $urandom_range(0, 4) == 0)
        begin
            char_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        char_valid    <= 1'b1;
        character     <= c;
        start_of_text <= sot;
        end_of_text   <= eot;
        @(posedge clk);
        while (char_stall)
            @(posedge clk);
        void'(sb.note_item(c, sot, eot));
        handled++;
    endtask

    task automatic put(logic [7:0] c);
        if (garble && $urandom_range(0, 9) == 0)
            c = 8'($urandom_range(0, 255));
        push_char(c, fresh_text, 1'b0);
        fresh_text = 1'b0;
    endtask

    task automatic put_end();
        push_char(8'($urandom_range(0, 255)), fresh_text, 1'b1);
        fresh_text = 1'b0;
    endtask

    task automatic send_string(string s);
        for (int i = 0; i < s.len(); i++)
            put(s[i]);
    endtask

    task automatic drain();
        char_valid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [7:0] any_letter();
        return 8'(32'h41 + $urandom_range(0, 25) + ($urandom_range(0, 1) ? 32'h20 : 32'h0));
    endfunction

    function automatic logic [7:0] any_blank();
        return ($urandom_range(0, 5) == 0) ? sexpr_pkg::CHAR_SPACE
                                           : 8'(32'h09 + $urandom_range(0, 4));
    endfunction

    task automatic send_text(bit broken);
        logic [7:0] c;
        fresh_text = 1'b1;
        garble     = broken;
        repeat ($urandom_range(1, 12))
        begin
            case ($urandom_range(0, broken ? 6 : 5))
                0: put(sexpr_pkg::CHAR_LPAREN);
                1: put(sexpr_pkg::CHAR_RPAREN);
                2: put(sexpr_pkg::CHAR_QUOTE);
                3:
                begin
                    put(any_letter());
                    repeat ($urandom_range(0, 7))
                    begin
                        case ($urandom_range(0, 5))
                            0: put(sexpr_pkg::CHAR_DASH);
                            1: put(sexpr_pkg::CHAR_UNDERSCORE);
                            default: put(any_letter());
                        endcase
                    end
                    if ($urandom_range(0, 3) == 0)
                        put(sexpr_pkg::CHAR_RPAREN);
                    else
                        put(any_blank());
                end
                4, 6:
                begin
                    put(sexpr_pkg::CHAR_DQUOTE);
                    repeat ($urandom_range(0, 8))
                    begin
                        c = 8'($urandom_range(0, 255));
                        if (c == sexpr_pkg::CHAR_LF || c == sexpr_pkg::CHAR_DQUOTE
                            || c == sexpr_pkg::CHAR_QUOTE)
                            c = "x";
                        put(c);
                    end
                    if (!broken)
                        put($urandom_range(0, 1) ? sexpr_pkg::CHAR_DQUOTE
                                                 : sexpr_pkg::CHAR_QUOTE);
                end
                default: put(any_blank());
            endcase
        end
        garble = 1'b0;
        if ($urandom_range(0, 7) != 0)
            put_end();
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 20))
            push_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                      $urandom_range(0, 7) == 0);
    endtask

    initial
    begin : stimulus
        int texts;
        int pick;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        fresh_text = 1'b1;
        send_string("(A-_z)'");
        put(sexpr_pkg::CHAR_CR);
        put(sexpr_pkg::CHAR_LF);
        put(sexpr_pkg::CHAR_TAB);
        put(sexpr_pkg::CHAR_SPACE);
        put(8'h0B);
        put(8'h0C);
        put(sexpr_pkg::CHAR_DQUOTE);
        put(sexpr_pkg::CHAR_CR);
        put(8'hFF);
        put(sexpr_pkg::CHAR_QUOTE);
        send_string("\"q\"k m");
        put_end();
        put_end();
        fresh_text = 1'b1;
        send_string("\"x");
        put_end();
        put("a");
        fresh_text = 1'b1;
        put(sexpr_pkg::CHAR_DQUOTE);
        put(sexpr_pkg::CHAR_LF);
        fresh_text = 1'b1;
        send_string("a1");
        fresh_text = 1'b1;
        put("#");
        fresh_text = 1'b1;
        put(8'h80);
        fresh_text = 1'b1;
        put_end();
        drain();

        handled = 0;
        texts   = 0;
        while (handled < ITEM_GOAL)
        begin
            if (handled > ITEM_GOAL - 300)
                idling = 1'b0;
            pick = $urandom_range(0, 9);
            if (pick < 7)
                send_text(1'b0);
            else if (pick < 9)
                send_text(1'b1);
            else
                send_noise();
            texts++;
            if (texts % 40 == 0)
                drain();
        end

        char_valid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

@@ filelist.f @@
hw/rtl/sexpr_pkg.sv
hw/rtl/sexpr_queue.sv
hw/rtl/sexpr_front.sv
hw/rtl/sexpr_back.sv
hw/rtl/sexpr_tokenizer_unit.sv
hw/rtl/sexpr_checker.sv
tb/testbench.sv
